// File: rtl/core/fip_pkg.sv
`default_nettype none
package fip_pkg;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;

    localparam int SIG_W  = 48;
    localparam int QUOT_W = 26;
    localparam int EXP_W  = 11;

    localparam logic signed [EXP_W-1:0] MUL_EXP_ADJ = 11'sd126;
    localparam logic signed [EXP_W-1:0] DIV_EXP_ADJ = 11'sd127;
    localparam logic signed [EXP_W-1:0] EXP_INF     = 11'sd255;

endpackage
`default_nettype wire

// File: rtl/core/float32_integer_power_unit.sv
`default_nettype none
// Operation: a zero power gives one directly from idle; otherwise a search for the
// leading one of the power magnitude, then per exponent bit one or two float
// operations, each an operand normalize, a multiply or a divide of 26 quotient bits,
// a result normalize that shifts right on underflow, and rounding.
// Throughput: one item at a time; busy stays high until done pulses.
// Reset: rst_n asynchronous; clears the sequencer and the done strobe.
module float32_integer_power_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] base_bits,
    input  wire logic [31:0] power,
    output logic             done,
    output logic [31:0]      result_bits
);

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_LOAD, S_UNPACK, S_PRENORM, S_MUL, S_DIV,
        S_NORM, S_ROUND, S_WB
    } state_t;

    localparam int EW = fip_pkg::EXP_W;
    localparam int SW = fip_pkg::SIG_W;
    localparam int QW = fip_pkg::QUOT_W;

    state_t                state_reg;
    logic                  done_reg;
    logic [31:0]           result_reg;
    logic [31:0]           x_reg;
    logic [31:0]           mag_reg;
    logic [5:0]            cnt_reg;
    logic                  neg_reg;
    logic                  phase_reg;
    logic [31:0]           acc_reg;
    logic [31:0]           tmp_reg;
    logic [31:0]           a_reg;
    logic [31:0]           b_reg;
    logic                  div_reg;
    logic [31:0]           r_reg;
    logic                  sign_reg;
    logic [23:0]           ma_reg;
    logic [23:0]           mb_reg;
    logic signed [EW-1:0]  ea_reg;
    logic signed [EW-1:0]  eb_reg;
    logic [24:0]           rem_reg;
    logic [QW-1:0]         q_reg;
    logic [4:0]            dcnt_reg;
    logic [SW-1:0]         sig_reg;
    logic                  stk_reg;
    logic signed [EW-1:0]  e_reg;

    logic [31:0] neg_power;
    logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic [31:0] special_bits;
    logic        special_hit;
    logic        rem_ge;
    logic [23:0] m24;
    logic        rnd_up;
    logic [24:0] m25;
    logic [23:0] mant_r;
    logic signed [EW-1:0] e_r;
    logic [31:0] round_bits;

    assign neg_power = 32'd0 - power;

    always_comb
    begin
        a_nan  = (a_reg[30:23] == fip_pkg::EXP_MAX) && (a_reg[22:0] != 23'd0);
        a_inf  = (a_reg[30:23] == fip_pkg::EXP_MAX) && (a_reg[22:0] == 23'd0);
        a_zero = (a_reg[30:0] == 31'd0);
        b_nan  = (b_reg[30:23] == fip_pkg::EXP_MAX) && (b_reg[22:0] != 23'd0);
        b_inf  = (b_reg[30:23] == fip_pkg::EXP_MAX) && (b_reg[22:0] == 23'd0);
        b_zero = (b_reg[30:0] == 31'd0);
        special_hit  = 1'b1;
        special_bits = fip_pkg::QNAN_BITS;
        if (!div_reg)
        begin
            priority if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
                special_bits = fip_pkg::QNAN_BITS;
            else if (a_inf || b_inf)
                special_bits = {a_reg[31] ^ b_reg[31], fip_pkg::EXP_MAX, 23'd0};
            else if (a_zero || b_zero)
                special_bits = {a_reg[31] ^ b_reg[31], 31'd0};
            else
                special_hit = 1'b0;
        end
        else
        begin
            priority if (a_nan || b_nan || (a_zero && b_zero) || (a_inf && b_inf))
                special_bits = fip_pkg::QNAN_BITS;
            else if (b_zero || a_inf)
                special_bits = {a_reg[31] ^ b_reg[31], fip_pkg::EXP_MAX, 23'd0};
            else if (b_inf || a_zero)
                special_bits = {a_reg[31] ^ b_reg[31], 31'd0};
            else
                special_hit = 1'b0;
        end
    end

    assign rem_ge = (rem_reg >= {1'b0, mb_reg});

    always_comb
    begin
        m24    = sig_reg[SW-1 -: 24];
        rnd_up = sig_reg[SW-25] & ((|sig_reg[SW-26:0]) | stk_reg | m24[0]);
        m25    = {1'b0, m24} + {24'd0, rnd_up};
        if (m25[24])
        begin
            mant_r = m25[24:1];
            e_r    = e_reg + 11'sd1;
        end
        else
        begin
            mant_r = m25[23:0];
            e_r    = e_reg;
        end
        if (e_r >= fip_pkg::EXP_INF)
            round_bits = {sign_reg, fip_pkg::EXP_MAX, 23'd0};
        else if (mant_r[23])
            round_bits = {sign_reg, e_r[7:0], mant_r[22:0]};
        else
            round_bits = {sign_reg, 8'd0, mant_r[22:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= base_bits;
                        neg_reg   <= power[31];
                        mag_reg   <= power[31] ? neg_power : power;
                        cnt_reg   <= 6'd32;
                        acc_reg   <= fip_pkg::ONE_BITS;
                        phase_reg <= 1'b0;
                        if (power == 32'd0)
                        begin
                            result_reg <= fip_pkg::ONE_BITS;
                            done_reg   <= 1'b1;
                        end
                        else
                            state_reg <= S_FIND;
                    end
                end
                S_FIND:
                begin
                    if (mag_reg[31])
                        state_reg <= S_LOAD;
                    else
                    begin
                        mag_reg <= {mag_reg[30:0], 1'b0};
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_LOAD:
                begin
                    if (!phase_reg)
                    begin
                        a_reg   <= (mag_reg[31] && !neg_reg) ? x_reg : acc_reg;
                        b_reg   <= acc_reg;
                        div_reg <= 1'b0;
                    end
                    else
                    begin
                        a_reg   <= tmp_reg;
                        b_reg   <= neg_reg ? x_reg : acc_reg;
                        div_reg <= neg_reg;
                    end
                    state_reg <= S_UNPACK;
                end
                S_UNPACK:
                begin
                    sign_reg <= a_reg[31] ^ b_reg[31];
                    ma_reg   <= {a_reg[30:23] != 8'd0, a_reg[22:0]};
                    mb_reg   <= {b_reg[30:23] != 8'd0, b_reg[22:0]};
                    ea_reg   <= (a_reg[30:23] == 8'd0) ? 11'sd1 : $signed({3'd0, a_reg[30:23]});
                    eb_reg   <= (b_reg[30:23] == 8'd0) ? 11'sd1 : $signed({3'd0, b_reg[30:23]});
                    if (special_hit)
                    begin
                        r_reg     <= special_bits;
                        state_reg <= S_WB;
                    end
                    else
                        state_reg <= S_PRENORM;
                end
                S_PRENORM:
                begin
                    if (!ma_reg[23])
                    begin
                        ma_reg <= {ma_reg[22:0], 1'b0};
                        ea_reg <= ea_reg - 11'sd1;
                    end
                    if (!mb_reg[23])
                    begin
                        mb_reg <= {mb_reg[22:0], 1'b0};
                        eb_reg <= eb_reg - 11'sd1;
                    end
                    if (ma_reg[23] && mb_reg[23])
                    begin
                        rem_reg   <= {1'b0, ma_reg};
                        dcnt_reg  <= 5'(QW - 1);
                        state_reg <= div_reg ? S_DIV : S_MUL;
                    end
                end
                S_MUL:
                begin
                    sig_reg   <= ma_reg * mb_reg;
                    stk_reg   <= 1'b0;
                    e_reg     <= ea_reg + eb_reg - fip_pkg::MUL_EXP_ADJ;
                    state_reg <= S_NORM;
                end
                S_DIV:
                begin
                    q_reg    <= {q_reg[QW-2:0], rem_ge};
                    rem_reg  <= {(rem_ge ? (rem_reg[23:0] - mb_reg) : rem_reg[23:0]), 1'b0};
                    dcnt_reg <= dcnt_reg - 5'd1;
                    if (dcnt_reg == 5'd0)
                    begin
                        e_reg     <= ea_reg - eb_reg + fip_pkg::DIV_EXP_ADJ;
                        state_reg <= S_NORM;
                    end
                    if (dcnt_reg == 5'd0)
                    begin
                        sig_reg <= {q_reg[QW-2:0], rem_ge, {(SW-QW){1'b0}}};
                        stk_reg <= rem_ge ? (rem_reg[23:0] != mb_reg) : (rem_reg != 25'd0);
                    end
                end
                S_NORM:
                begin
                    priority if (e_reg < 11'sd1)
                    begin
                        if (sig_reg == '0)
                            e_reg <= 11'sd1;
                        else
                        begin
                            sig_reg <= {1'b0, sig_reg[SW-1:1]};
                            stk_reg <= stk_reg | sig_reg[0];
                            e_reg   <= e_reg + 11'sd1;
                        end
                    end
                    else if (!sig_reg[SW-1] && e_reg > 11'sd1)
                    begin
                        sig_reg <= {sig_reg[SW-2:0], 1'b0};
                        e_reg   <= e_reg - 11'sd1;
                    end
                    else
                        state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    r_reg     <= round_bits;
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (!phase_reg && mag_reg[31])
                    begin
                        tmp_reg   <= r_reg;
                        phase_reg <= 1'b1;
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        acc_reg   <= r_reg;
                        phase_reg <= 1'b0;
                        mag_reg   <= {mag_reg[30:0], 1'b0};
                        cnt_reg   <= cnt_reg - 6'd1;
                        if (cnt_reg == 6'd1)
                        begin
                            result_reg <= r_reg;
                            done_reg   <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else
                            state_reg <= S_LOAD;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign result_bits = result_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done strobe while busy");

    a_zero_power: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && power == 32'd0) |=> (done && result_bits == fip_pkg::ONE_BITS))
        else $error("zero power did not give one");

    a_round_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (e_reg >= 11'sd1))
        else $error("rounding entered below the subnormal exponent");

    a_div_prenorm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (mb_reg[23] && div_reg))
        else $error("divide started on an unnormalized divisor");

endmodule
`default_nettype wire
